FILE: rtl/core/fmpf_pkg.sv
`timescale 1ns / 1ps
package fmpf_pkg;

  // Rule table geometry.
  localparam int SLOTS  = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int HC_W   = 64;

  // Item modes.
  localparam logic [1:0] MODE_CHECK = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_DEL   = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  // Rule direction that matches either way.
  localparam logic [1:0] DIR_BOTH = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  // Response kinds from the controller to the datapath.
  localparam logic [2:0] RSP_NONE = 3'd0;
  localparam logic [2:0] RSP_ZERO = 3'd1;
  localparam logic [2:0] RSP_ADD  = 3'd2;
  localparam logic [2:0] RSP_FULL = 3'd3;
  localparam logic [2:0] RSP_BAD  = 3'd4;
  localparam logic [2:0] RSP_MISS = 3'd5;
  localparam logic [2:0] RSP_HIT  = 3'd6;

  // One stored rule.
  typedef struct packed {
    logic        action;
    logic [7:0]  proto;
    logic [1:0]  dir;
    logic [31:0] src_addr;
    logic [31:0] src_netmask;
    logic [31:0] dst_addr;
    logic [31:0] dst_netmask;
    logic [15:0] sport;
    logic [15:0] dport;
  } rule_t;

  // Commands from the controller.
  typedef struct packed {
    logic       latch_pkt;
    logic       add_rule;
    logic       del_rule;
    logic       scan_clr;
    logic       scan_run;
    logic       cnt_upd;
    logic [2:0] rsp;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_ok;
    logic hit;
    logic more;
    logic cmp_vld;
  } stat_t;

endpackage

FILE: rtl/core/fmpf_ram.sv
`timescale 1ns / 1ps
module fmpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/fmpf_ctrl.sv
`timescale 1ns / 1ps
module fmpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_mode,
  input  logic                filter_en,
  input  fmpf_pkg::stat_t     stat,
  output fmpf_pkg::cmd_t      cmd,
  output logic                busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CNT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rsp   = fmpf_pkg::RSP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_mode)
            fmpf_pkg::MODE_CHECK: begin
              cmd.latch_pkt = 1'b1;
              if (!filter_en) begin
                cmd.rsp = fmpf_pkg::RSP_ZERO;
              end else if (stat.empty) begin
                cmd.rsp = fmpf_pkg::RSP_MISS;
              end else begin
                cmd.scan_clr = 1'b1;
                state_nxt    = ST_SCAN;
              end
            end
            fmpf_pkg::MODE_ADD: begin
              if (stat.full) begin
                cmd.rsp = fmpf_pkg::RSP_FULL;
              end else begin
                cmd.add_rule = 1'b1;
                cmd.rsp      = fmpf_pkg::RSP_ADD;
              end
            end
            fmpf_pkg::MODE_DEL: begin
              if (stat.idx_ok) begin
                cmd.del_rule = 1'b1;
                cmd.rsp      = fmpf_pkg::RSP_ZERO;
              end else begin
                cmd.rsp = fmpf_pkg::RSP_BAD;
              end
            end
            default: cmd.rsp = fmpf_pkg::RSP_ZERO;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          state_nxt = ST_CNT;
        end else if (!stat.cmp_vld && !stat.more) begin
          cmd.rsp   = fmpf_pkg::RSP_MISS;
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_CNT: begin
        cmd.cnt_upd = 1'b1;
        cmd.rsp     = fmpf_pkg::RSP_HIT;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/core/fmpf_dp.sv
`timescale 1ns / 1ps
module fmpf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fmpf_pkg::cmd_t       cmd,
  output fmpf_pkg::stat_t      stat,
  input  logic                 default_verdict,
  input  logic                 in_rule_action,
  input  logic [7:0]           in_protocol,
  input  logic [1:0]           in_direction,
  input  logic [31:0]          in_src_addr,
  input  logic [31:0]          in_src_mask,
  input  logic [31:0]          in_dst_addr,
  input  logic [31:0]          in_dst_mask,
  input  logic [15:0]          in_src_port,
  input  logic [15:0]          in_dst_port,
  input  logic [7:0]           in_rule_index,
  output logic                 out_valid,
  output logic                 out_verdict,
  output logic [1:0]           out_status,
  output logic [4:0]           out_slot,
  output logic                 out_hit,
  output logic [63:0]          out_hit_count
);

  localparam int SW = fmpf_pkg::SLOT_W;
  localparam int CW = fmpf_pkg::CNT_W;
  localparam int HW = fmpf_pkg::HC_W;

  logic [CW-1:0]             used_r;
  logic [fmpf_pkg::SLOTS-1:0] active_r;
  logic [CW-1:0]             scan_idx_r;
  logic [SW-1:0]             cmp_idx_r;
  logic                      cmp_vld_r;
  logic                      hit_act_r;

  logic [7:0]  pk_proto_r;
  logic [1:0]  pk_dir_r;
  logic [31:0] pk_sa_r, pk_da_r;
  logic [15:0] pk_sp_r, pk_dp_r;

  fmpf_pkg::rule_t rule_wr, rule_rd;
  logic [HW-1:0]   cnt_rd, cnt_inc, cnt_wdata;
  logic [SW-1:0]   cnt_waddr;
  logic            cnt_we;
  logic            match;

  logic            out_valid_r, out_verdict_r, out_hit_r;
  logic [1:0]      out_status_r;
  logic [4:0]      out_slot_r;
  logic [HW-1:0]   out_hit_count_r;

  logic            out_verdict_nxt, out_hit_nxt;
  logic [1:0]      out_status_nxt;
  logic [4:0]      out_slot_nxt;
  logic [HW-1:0]   out_hit_count_nxt;

  // Rule being added, straight from the input ports.
  always_comb begin
    rule_wr.action      = in_rule_action;
    rule_wr.proto       = in_protocol;
    rule_wr.dir         = in_direction;
    rule_wr.src_addr    = in_src_addr;
    rule_wr.src_netmask = in_src_mask;
    rule_wr.dst_addr    = in_dst_addr;
    rule_wr.dst_netmask = in_dst_mask;
    rule_wr.sport       = in_src_port;
    rule_wr.dport       = in_dst_port;
  end

  fmpf_ram #(
    .WIDTH($bits(fmpf_pkg::rule_t)),
    .DEPTH(fmpf_pkg::SLOTS)
  ) u_rule_ram (
    .clk   (clk),
    .we    (cmd.add_rule),
    .waddr (used_r[SW-1:0]),
    .wdata (rule_wr),
    .raddr (scan_idx_r[SW-1:0]),
    .rdata (rule_rd)
  );

  // Counters are cleared on add and bumped on a hit.
  assign cnt_inc   = cnt_rd + HW'(1);
  assign cnt_we    = cmd.add_rule | cmd.cnt_upd;
  assign cnt_waddr = cmd.add_rule ? used_r[SW-1:0] : cmp_idx_r;
  assign cnt_wdata = cmd.add_rule ? '0 : cnt_inc;

  fmpf_ram #(
    .WIDTH(HW),
    .DEPTH(fmpf_pkg::SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cmp_idx_r),
    .rdata (cnt_rd)
  );

  // Compare the rule read last cycle against the packet.
  always_comb begin
    match = active_r[cmp_idx_r]
          && (rule_rd.dir == fmpf_pkg::DIR_BOTH || rule_rd.dir == pk_dir_r)
          && (rule_rd.proto == 8'd0 || rule_rd.proto == pk_proto_r)
          && (rule_rd.src_addr == 32'd0
              || (pk_sa_r & rule_rd.src_netmask)
                 == (rule_rd.src_addr & rule_rd.src_netmask))
          && (rule_rd.dst_addr == 32'd0
              || (pk_da_r & rule_rd.dst_netmask)
                 == (rule_rd.dst_addr & rule_rd.dst_netmask))
          && (rule_rd.sport == 16'd0 || rule_rd.sport == pk_sp_r)
          && (rule_rd.dport == 16'd0 || rule_rd.dport == pk_dp_r);
  end

  // Status toward the controller.
  always_comb begin
    stat.full    = (used_r == CW'(fmpf_pkg::SLOTS));
    stat.empty   = (used_r == '0);
    stat.idx_ok  = (32'(in_rule_index) < 32'(used_r));
    stat.hit     = cmp_vld_r & match;
    stat.more    = (scan_idx_r < used_r);
    stat.cmp_vld = cmp_vld_r;
  end

  // Table bookkeeping and scan pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      active_r   <= '0;
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      if (cmd.add_rule) begin
        used_r                   <= used_r + CW'(1);
        active_r[used_r[SW-1:0]] <= 1'b1;
      end
      if (cmd.del_rule) begin
        active_r[in_rule_index[SW-1:0]] <= 1'b0;
      end
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else if (cmd.scan_run) begin
        cmp_vld_r <= stat.more;
        if (stat.more) begin
          scan_idx_r <= scan_idx_r + CW'(1);
        end
      end
    end
  end

  // Packet fields and the slot under compare.
  always_ff @(posedge clk) begin
    if (cmd.latch_pkt) begin
      pk_proto_r <= in_protocol;
      pk_dir_r   <= in_direction;
      pk_sa_r    <= in_src_addr;
      pk_da_r    <= in_dst_addr;
      pk_sp_r    <= in_src_port;
      pk_dp_r    <= in_dst_port;
    end
    if (cmd.scan_run && stat.more) begin
      cmp_idx_r <= scan_idx_r[SW-1:0];
    end
    if (stat.hit) begin
      hit_act_r <= rule_rd.action;
    end
  end

  // Result register: one strobe cycle per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.rsp != fmpf_pkg::RSP_NONE);
    end
  end

  // Result fields for the response kind; unused fields stay zero.
  always_comb begin
    out_verdict_nxt   = 1'b0;
    out_status_nxt    = fmpf_pkg::STAT_OK;
    out_slot_nxt      = '0;
    out_hit_nxt       = 1'b0;
    out_hit_count_nxt = '0;
    case (cmd.rsp)
      fmpf_pkg::RSP_ADD:  out_slot_nxt = 5'(used_r);
      fmpf_pkg::RSP_FULL: out_status_nxt = fmpf_pkg::STAT_FULL;
      fmpf_pkg::RSP_BAD:  out_status_nxt = fmpf_pkg::STAT_BAD;
      fmpf_pkg::RSP_MISS: out_verdict_nxt = default_verdict;
      fmpf_pkg::RSP_HIT: begin
        out_verdict_nxt   = hit_act_r;
        out_slot_nxt      = 5'(cmp_idx_r);
        out_hit_nxt       = 1'b1;
        out_hit_count_nxt = cnt_inc;
      end
      default: out_verdict_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    out_verdict_r   <= out_verdict_nxt;
    out_status_r    <= out_status_nxt;
    out_slot_r      <= out_slot_nxt;
    out_hit_r       <= out_hit_nxt;
    out_hit_count_r <= out_hit_count_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_verdict   = out_verdict_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_hit       = out_hit_r;
  assign out_hit_count = out_hit_count_r;

endmodule

FILE: rtl/core/first_match_packet_filter.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     start / busy           in_mode .. in_rule_index
// result    out_valid (1 cycle)    out_verdict, out_status, out_slot, out_hit, out_hit_count
// config    psel/penable/pready    paddr, pwdata, prdata
//
// Add, delete and reserved commands, and checks when disabled or on an empty table, are
// answered from idle; the result shows the next cycle. A check scans the rule memory one
// slot per cycle up to the first hit or the last used slot; a hit adds a counter-update state.
// Reset resets the rule count, active bits, scan state, out_valid and config; no clearing pass.
// The receiver cannot stall; each result transfer lasts exactly one cycle.
module first_match_packet_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic        in_rule_action,
  input  logic [7:0]  in_protocol,
  input  logic [1:0]  in_direction,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_src_mask,
  input  logic [31:0] in_dst_addr,
  input  logic [31:0] in_dst_mask,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_rule_index,
  output logic        out_valid,
  output logic        out_verdict,
  output logic [1:0]  out_status,
  output logic [4:0]  out_slot,
  output logic        out_hit,
  output logic [63:0] out_hit_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fmpf_pkg::cmd_t  cmd;
  fmpf_pkg::stat_t stat;
  logic            filter_en_r, default_verdict_r;
  logic            cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r       <= 1'b1;
      default_verdict_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr == 3'd0) begin
        filter_en_r <= pwdata[0];
      end
      if (paddr == 3'd4) begin
        default_verdict_r <= pwdata[0];
      end
    end
  end

  always_comb begin
    case (paddr)
      3'd0:    prdata = {31'd0, filter_en_r};
      3'd4:    prdata = {31'd0, default_verdict_r};
      default: prdata = 32'd0;
    endcase
  end

  fmpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .filter_en (filter_en_r),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  fmpf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .default_verdict (default_verdict_r),
    .in_rule_action  (in_rule_action),
    .in_protocol     (in_protocol),
    .in_direction    (in_direction),
    .in_src_addr     (in_src_addr),
    .in_src_mask     (in_src_mask),
    .in_dst_addr     (in_dst_addr),
    .in_dst_mask     (in_dst_mask),
    .in_src_port     (in_src_port),
    .in_dst_port     (in_dst_port),
    .in_rule_index   (in_rule_index),
    .out_valid       (out_valid),
    .out_verdict     (out_verdict),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_hit         (out_hit),
    .out_hit_count   (out_hit_count)
  );

endmodule

FILE: dv/first_match_packet_filter_tb.sv
`timescale 1ns / 1ps
module first_match_packet_filter_tb;

  localparam logic [2:0] REG_FILTER_EN = 3'd0;
  localparam logic [2:0] REG_DEFAULT   = 3'd4;
  localparam int         CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [1:0]  mode;
    logic        act;
    logic [7:0]  proto;
    logic [1:0]  dir;
    logic [31:0] sa;
    logic [31:0] sm;
    logic [31:0] da;
    logic [31:0] dm;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  idx;
  } pkt_cmd_t;

  typedef struct packed {
    logic        verdict;
    logic [1:0]  status;
    logic [4:0]  slot;
    logic        hit;
    logic [63:0] hit_count;
  } filt_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic        in_rule_action = 1'b0;
  logic [7:0]  in_protocol = '0;
  logic [1:0]  in_direction = '0;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_src_mask = '0;
  logic [31:0] in_dst_addr = '0;
  logic [31:0] in_dst_mask = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [7:0]  in_rule_index = '0;
  logic        out_valid;
  logic        out_verdict;
  logic [1:0]  out_status;
  logic [4:0]  out_slot;
  logic        out_hit;
  logic [63:0] out_hit_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the rule table and the registers.
  fmpf_pkg::rule_t acl_rules [fmpf_pkg::SLOTS];
  logic         acl_active [fmpf_pkg::SLOTS];
  logic [63:0]  acl_counts [fmpf_pkg::SLOTS];
  int           acl_used = 0;
  logic         filt_en = 1'b1;
  logic         filt_dflt = 1'b0;

  // Rules as the stimulus generator has queued them, in add order.
  fmpf_pkg::rule_t gen_rules [fmpf_pkg::SLOTS];
  int           gen_used = 0;

  pkt_cmd_t     pending_cmds [$];
  filt_result_t expected_results [$];
  pkt_cmd_t     cur_cmd;
  logic         took = 1'b0;
  logic         no_gaps = 1'b0;
  int           gap_left = 0;
  int           gap_next = 0;
  int           errors = 0;
  int           cycles = 0;

  first_match_packet_filter uut (.*);

  always #2 clk = ~clk;

  function automatic logic addr_hit(logic [31:0] ra, logic [31:0] rm, logic [31:0] pa);
    return ra == '0 || (pa & rm) == (ra & rm);
  endfunction

  function automatic logic rule_hits(fmpf_pkg::rule_t r, pkt_cmd_t c);
    return (r.dir == fmpf_pkg::DIR_BOTH || r.dir == c.dir) &&
           (r.proto == '0 || r.proto == c.proto) &&
           addr_hit(r.src_addr, r.src_netmask, c.sa) &&
           addr_hit(r.dst_addr, r.dst_netmask, c.da) &&
           (r.sport == '0 || r.sport == c.sp) && (r.dport == '0 || r.dport == c.dp);
  endfunction

  function automatic fmpf_pkg::rule_t rule_of(pkt_cmd_t c);
    fmpf_pkg::rule_t r;
    r.action = c.act;
    r.proto = c.proto;
    r.dir = c.dir;
    r.src_addr = c.sa;
    r.src_netmask = c.sm;
    r.dst_addr = c.da;
    r.dst_netmask = c.dm;
    r.sport = c.sp;
    r.dport = c.dp;
    return r;
  endfunction

  // Applies one command to the shadow table and returns its result.
  function automatic filt_result_t classify(pkt_cmd_t c);
    filt_result_t r;
    logic found;
    r = '0;
    found = 1'b0;
    case (c.mode)
      fmpf_pkg::MODE_CHECK: if (filt_en) begin
        for (int i = 0; i < acl_used && !found; i++) begin
          if (acl_active[i] && rule_hits(acl_rules[i], c)) begin
            found = 1'b1;
            acl_counts[i] = acl_counts[i] + 64'd1;
            r.verdict = acl_rules[i].action;
            r.slot = i[4:0];
            r.hit = 1'b1;
            r.hit_count = acl_counts[i];
          end
        end
        if (!found) r.verdict = filt_dflt;
      end
      fmpf_pkg::MODE_ADD: if (acl_used >= fmpf_pkg::SLOTS) begin
        r.status = fmpf_pkg::STAT_FULL;
      end else begin
        acl_rules[acl_used] = rule_of(c);
        acl_active[acl_used] = 1'b1;
        acl_counts[acl_used] = '0;
        r.slot = acl_used[4:0];
        acl_used++;
      end
      fmpf_pkg::MODE_DEL: if (c.idx >= acl_used) begin
        r.status = fmpf_pkg::STAT_BAD;
      end else begin
        acl_active[c.idx] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic pkt_cmd_t random_cmd(logic [1:0] mode);
    pkt_cmd_t c;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(pkt_cmd_t)-1:0];
    c.mode = mode;
    return c;
  endfunction

  function automatic logic [31:0] prefix_mask();
    int len;
    len = $urandom_range(0, 32);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return (len == 0) ? 32'd0 : ~32'd0 << (32 - len);
  endfunction

  // Queues one command and tracks adds so later checks can aim at them.
  task automatic queue_cmd(pkt_cmd_t c);
    if (c.mode == fmpf_pkg::MODE_ADD && gen_used < fmpf_pkg::SLOTS) begin
      gen_rules[gen_used] = rule_of(c);
      gen_used++;
    end
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random_rule();
    pkt_cmd_t c;
    c = random_cmd(fmpf_pkg::MODE_ADD);
    c.dir = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 1)) c.proto = '0;
    if ($urandom_range(0, 3) == 0) c.sa = '0;
    if ($urandom_range(0, 3) == 0) c.da = '0;
    c.sm = prefix_mask();
    c.dm = prefix_mask();
    if ($urandom_range(0, 1)) c.sp = '0;
    if ($urandom_range(0, 1)) c.dp = '0;
    queue_cmd(c);
  endtask

  // A packet built to satisfy one of the queued rules, with random content elsewhere.
  task automatic queue_aimed_check();
    pkt_cmd_t c;
    fmpf_pkg::rule_t r;
    c = random_cmd(fmpf_pkg::MODE_CHECK);
    r = gen_rules[$urandom_range(0, gen_used - 1)];
    c.dir = (r.dir == fmpf_pkg::DIR_BOTH) ? c.dir : r.dir;
    if (r.proto != '0) c.proto = r.proto;
    if (r.src_addr != '0) c.sa = (r.src_addr & r.src_netmask) | (c.sa & ~r.src_netmask);
    if (r.dst_addr != '0) c.da = (r.dst_addr & r.dst_netmask) | (c.da & ~r.dst_netmask);
    if (r.sport != '0) c.sp = r.sport;
    if (r.dport != '0) c.dp = r.dport;
    queue_cmd(c);
  endtask

  task automatic queue_random_mix(int count);
    pkt_cmd_t c;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_random_rule();
      end else if (pick < 14) begin
        c = random_cmd(fmpf_pkg::MODE_DEL);
        if ($urandom_range(0, 3) != 0) c.idx = 8'($urandom_range(0, gen_used + 1));
        queue_cmd(c);
      end else if (pick < 16) begin
        queue_cmd(random_cmd(fmpf_pkg::MODE_RSVD));
      end else if (pick < 70 && gen_used > 0) begin
        queue_aimed_check();
      end else begin
        queue_cmd(random_cmd(fmpf_pkg::MODE_CHECK));
      end
    end
  endtask

  // Waits until every queued command has been taken and answered.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_FILTER_EN) filt_en = data[0];
    else filt_dflt = data[0];
  endtask

  // Command driver: holds start until the transfer is taken, then idles at random.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !took) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else begin
        cur_cmd = pending_cmds.pop_front();
        in_mode <= cur_cmd.mode;
        in_rule_action <= cur_cmd.act;
        in_protocol <= cur_cmd.proto;
        in_direction <= cur_cmd.dir;
        in_src_addr <= cur_cmd.sa;
        in_src_mask <= cur_cmd.sm;
        in_dst_addr <= cur_cmd.da;
        in_dst_mask <= cur_cmd.dm;
        in_src_port <= cur_cmd.sp;
        in_dst_port <= cur_cmd.dp;
        in_rule_index <= cur_cmd.idx;
        start <= 1'b1;
        gap_next = $urandom_range(0, 9);
        if (no_gaps || gap_next < 6) gap_left <= 0;
        else if (gap_next < 9) gap_left <= $urandom_range(1, 3);
        else gap_left <= $urandom_range(10, 40);
      end
    end
  end

  // Result monitor and predictor: answers are checked before the next command is logged.
  always @(posedge clk) begin
    filt_result_t want;
    took <= start && !busy;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          errors++;
        end
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          errors++;
        end
        if (out_hit_count !== want.hit_count) begin
          $error("hit_count: expected %0d, got %0d", want.hit_count, out_hit_count);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      expected_results.push_back(classify({in_mode, in_rule_action, in_protocol,
        in_direction, in_src_addr, in_src_mask, in_dst_addr, in_dst_mask,
        in_src_port, in_dst_port, in_rule_index}));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_match_packet_filter_tb: errors");
      $finish;
    end
  end

  initial begin
    pkt_cmd_t c;
    for (int i = 0; i < fmpf_pkg::SLOTS; i++) begin
      acl_active[i] = 1'b0;
      acl_counts[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty table, both bad index forms, hits, deletes and extremes.
    reg_write(REG_FILTER_EN, 32'd1);
    reg_write(REG_DEFAULT, 32'd1);
    no_gaps = 1'b1;
    queue_cmd('0);
    queue_cmd(pkt_cmd_t'{mode: fmpf_pkg::MODE_DEL, idx: 8'd0, default: '0});
    c = '0;
    c.mode = fmpf_pkg::MODE_ADD;
    c.act = 1'b1;
    c.proto = 8'd6;
    c.sa = 32'h0A000000;
    c.sm = 32'hFF000000;
    c.da = 32'hFFFFFFFF;
    c.dm = 32'hFFFFFFFF;
    c.sp = 16'd80;
    c.dp = 16'd443;
    queue_cmd(c);
    c.mode = fmpf_pkg::MODE_CHECK;
    c.sa = 32'h0A123456;
    queue_cmd(c);
    queue_cmd(c);
    c.dir = 2'd1;
    queue_cmd(c);
    queue_cmd(pkt_cmd_t'{mode: fmpf_pkg::MODE_ADD, dir: fmpf_pkg::DIR_BOTH, dp: 16'hFFFF,
                         default: '0});
    c = '1;
    c.mode = fmpf_pkg::MODE_CHECK;
    queue_cmd(c);
    queue_cmd(pkt_cmd_t'{mode: fmpf_pkg::MODE_DEL, idx: 8'd0, default: '0});
    queue_cmd(pkt_cmd_t'{mode: fmpf_pkg::MODE_DEL, idx: 8'd0, default: '0});
    queue_cmd(c);
    c.mode = fmpf_pkg::MODE_RSVD;
    queue_cmd(c);
    queue_cmd(pkt_cmd_t'{mode: fmpf_pkg::MODE_DEL, idx: 8'hFF, default: '0});
    c = '0;
    c.dir = 2'd3;
    queue_cmd(c);
    wait_drained();

    // Random phases across the register settings; the rule table fills along the way.
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_FILTER_EN, (ph == 2 || ph == 3) ? 32'd0 : 32'd1);
      reg_write(REG_DEFAULT, {31'd0, ph[0]});
      no_gaps = (ph == 1);
      queue_random_mix(120);
      wait_drained();
      queue_random_mix(120);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("first_match_packet_filter_tb: clean");
    end else begin
      $display("first_match_packet_filter_tb: errors");
    end
    $finish;
  end

endmodule
